>>> src/sec_pkg.sv
// Shared types and constants for the Sobel edge classifier.
// No dependencies; imported by every module of the block.
package sec_pkg;

	// Geometry limits of the line buffers and counters
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 10;
	localparam int ROW_W      = 10;
	localparam int THR_W      = 11;

	// Result field widths
	localparam int OUT_POS_W = 9;
	localparam int MAG_W     = 21;
	localparam int CLASS_W   = 2;
	localparam int GRAD_W    = 11;
	localparam int SQ_W      = 20;
	localparam int THR_SQ_W  = 2 * THR_W;

	// Gradient queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd3;

	// Edge classes
	localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} geom_t;

	// One window result waiting for the magnitude stage
	typedef struct packed {
		logic [OUT_POS_W-1:0]     out_row;
		logic [OUT_POS_W-1:0]     out_col;
		logic                     frame_last;
		logic signed [GRAD_W-1:0] grad_v;
		logic signed [GRAD_W-1:0] grad_h;
	} grad_item_t;

endpackage

>>> src/sobel_edge_classifier_core.sv
// Top level of the streaming Sobel edge classifier: configuration registers
// and the front / queue / back chain. Depends on sec_pkg, sec_front,
// sec_queue and sec_back.
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ---------------------------------------
//  s_*      in   s_tvalid / s_tready   s_tdata: red, green, blue; s_tuser: flush
//  m_*      out  m_tvalid / m_tready   m_tdata: row, col, magnitude_sq, class;
//                                      m_tlast: frame_last
//  cfg_*    in   cfg_wr_en             cfg_index selects register, cfg_data
//
// One pixel transaction per clock sustained while the gradient queue has room. After
// the pixel completing its window is accepted, its result passes the line buffer
// read and gradients, queue write, squares, and classify into the output register.
// The single-port-per-side line buffer does one read and
// one write per pixel, which is what fixes the rate at one per clock.
// Reset clears counters, window and pointers; line buffer contents are
// don't-care until written. A stall on m_tready fills the 4-entry gradient
// queue, and s_tready drops once the queue and the in-flight pixel reach it.
module sobel_edge_classifier_core
	import sec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        s_tuser,   // flush
	// classified output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row[8:0], out_col[17:9], magnitude_sq[38:18],
	                               // edge_class[40:39], zero fill
	output logic        m_tlast,   // frame_last
	// configuration writes
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [THR_W-1:0] cfg_data
);

	logic [DIM_W-1:0] image_width_q, image_height_q;
	logic [THR_W-1:0] low_threshold_q, high_threshold_q;

	geom_t             geom;
	logic              push, q_pop, q_valid;
	grad_item_t        push_data, q_data;
	logic [QCNT_W-1:0] q_count;

	// Register file: dims keep their low 10 bits, thresholds all 11
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q    <= DIM_W'(400);
			image_height_q   <= DIM_W'(400);
			low_threshold_q  <= THR_W'(70);
			high_threshold_q <= THR_W'(200);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    image_width_q    <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q   <= cfg_data[DIM_W-1:0];
				REG_LOW_THRESHOLD:  low_threshold_q  <= cfg_data;
				REG_HIGH_THRESHOLD: high_threshold_q <= cfg_data;
				default:            image_width_q    <= image_width_q;
			endcase
		end
	end

	assign geom.image_width  = image_width_q;
	assign geom.image_height = image_height_q;

	// Front: position tracking, line buffer, window, gradients
	sec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.geom      (geom),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	// Gradient queue lets the back stall without freezing the front pipe
	sec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data),
		.count     (q_count)
	);

	// Back: squares, threshold compare, output register
	sec_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast)
	);

endmodule

>>> src/sec_front.sv
// Front end: accepts pixels, tracks raster position, keeps the line buffer
// and the 3x3 window, and produces gradients. Depends on sec_pkg.
module sec_front
	import sec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	input  logic        s_tuser,   // flush
	input  geom_t       geom,
	input  logic [QCNT_W-1:0] q_count,
	output logic        push,
	output grad_item_t  push_data
);

	localparam logic [19:0] GRAY_RECIP = 20'd683;
	localparam int GRAY_SHIFT = 11;

	logic accept;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [DIM_W-1:0] w_eff, h_eff;
	logic [DIM_W:0]   h_plus1;
	logic [9:0]       rgb_sum;
	logic [19:0]      gray_prod;
	logic [7:0]       gray_in;
	logic             col_zero;
	logic             emit_in, last_in, left_in, right_in;
	logic [OUT_POS_W-1:0] orow_in, ocol_in;
	logic [COL_W-1:0] col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic [DIM_W:0]   col_inc;

	// stage 1 registers
	logic             v_s1;
	logic             emit_s1, last_s1, left_s1, right_s1, top_en_s1, mid_en_s1;
	logic [OUT_POS_W-1:0] orow_s1, ocol_s1;
	logic [7:0]       gray_s1;
	logic [COL_W-1:0] addr_s1;
	logic             byp_s1;
	logic [15:0]      byp_data_s1;

	// line buffer: [15:8] two rows above, [7:0] row above
	logic [15:0] lbuf_mem [MAX_WIDTH];
	logic [15:0] lbuf_rd_q;
	logic [15:0] line_word;
	logic [15:0] wr_word;
	logic [7:0]  top_px, mid_px;

	logic [7:0] win_q [6];

	logic [7:0] lt, lm, lb, ct, cm, cb, rt, rm, rb;
	logic [9:0] sum_top, sum_bot, sum_left, sum_right;

	assign s_tready = (q_count + QCNT_W'(v_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (geom.image_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (geom.image_width > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = geom.image_width;
		end
		if (geom.image_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (geom.image_height > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = geom.image_height;
		end
	end

	assign h_plus1 = {1'b0, h_eff} + (DIM_W+1)'(1);

	// gray = (r+g+b)/3 via reciprocal, exact for sums below 2048
	assign rgb_sum   = 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
	assign gray_prod = 20'(rgb_sum) * GRAY_RECIP;
	assign gray_in   = (s_tuser || row_q >= h_eff) ? 8'd0
		: gray_prod[GRAY_SHIFT +: 8];

	assign col_zero = (col_q == '0);

	always_comb begin
		if (col_zero) begin
			// column 0 closes the previous row's last pixel
			emit_in  = (row_q >= ROW_W'(2)) && ({1'b0, row_q} <= h_plus1);
			orow_in  = OUT_POS_W'(row_q - ROW_W'(2));
			ocol_in  = OUT_POS_W'(w_eff - DIM_W'(1));
			last_in  = ({1'b0, row_q} == h_plus1);
			left_in  = (w_eff >= DIM_W'(2));
			right_in = 1'b0;
		end else begin
			emit_in  = (row_q >= ROW_W'(1)) && (row_q <= h_eff);
			orow_in  = OUT_POS_W'(row_q - ROW_W'(1));
			ocol_in  = OUT_POS_W'(col_q - COL_W'(1));
			last_in  = 1'b0;
			left_in  = (col_q >= COL_W'(2));
			right_in = 1'b1;
		end
	end

	assign col_inc = (DIM_W+1)'(col_q) + (DIM_W+1)'(1);

	always_comb begin
		if (col_zero && ({1'b0, row_q} >= h_plus1)) begin
			col_nxt = '0;
			row_nxt = '0;
		end else if (col_inc >= {1'b0, w_eff}) begin
			col_nxt = '0;
			row_nxt = row_q + ROW_W'(1);
		end else begin
			col_nxt = col_inc[COL_W-1:0];
			row_nxt = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= emit_in;
			last_s1     <= last_in;
			left_s1     <= left_in;
			right_s1    <= right_in;
			top_en_s1   <= (row_q >= ROW_W'(2));
			mid_en_s1   <= (row_q >= ROW_W'(1));
			orow_s1     <= orow_in;
			ocol_s1     <= ocol_in;
			gray_s1     <= gray_in;
			addr_s1     <= col_q;
			// write of the previous item lands at this same edge
			byp_s1      <= v_s1 && (addr_s1 == col_q);
			byp_data_s1 <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			lbuf_mem[addr_s1] <= wr_word;
		end
		if (accept) begin
			lbuf_rd_q <= lbuf_mem[col_q];
		end
	end

	assign line_word = byp_s1 ? byp_data_s1 : lbuf_rd_q;
	assign wr_word   = {line_word[7:0], gray_s1};
	assign top_px    = top_en_s1 ? line_word[15:8] : 8'd0;
	assign mid_px    = mid_en_s1 ? line_word[7:0] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= 8'd0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_px;
			win_q[4] <= mid_px;
			win_q[5] <= gray_s1;
		end
	end

	assign lt = left_s1  ? win_q[0] : 8'd0;
	assign lm = left_s1  ? win_q[1] : 8'd0;
	assign lb = left_s1  ? win_q[2] : 8'd0;
	assign ct = win_q[3];
	assign cm = win_q[4];
	assign cb = win_q[5];
	assign rt = right_s1 ? top_px  : 8'd0;
	assign rm = right_s1 ? mid_px  : 8'd0;
	assign rb = right_s1 ? gray_s1 : 8'd0;

	assign sum_top   = 10'(lt) + {1'b0, ct, 1'b0} + 10'(rt);
	assign sum_bot   = 10'(lb) + {1'b0, cb, 1'b0} + 10'(rb);
	assign sum_left  = 10'(lt) + {1'b0, lm, 1'b0} + 10'(lb);
	assign sum_right = 10'(rt) + {1'b0, rm, 1'b0} + 10'(rb);

	assign push                 = v_s1 && emit_s1;
	assign push_data.out_row    = orow_s1;
	assign push_data.out_col    = ocol_s1;
	assign push_data.frame_last = last_s1;
	assign push_data.grad_v     = $signed({1'b0, sum_top})  - $signed({1'b0, sum_bot});
	assign push_data.grad_h     = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});

endmodule

>>> src/sec_queue.sv
// Small gradient queue decoupling front and back of the classifier.
// Depends on sec_pkg.
module sec_queue
	import sec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  grad_item_t  push_data,
	input  logic        pop,
	output logic        pop_valid,
	output grad_item_t  pop_data,
	output logic [QCNT_W-1:0] count
);

	grad_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> src/sec_back.sv
// Back end: squares the gradients, sums them, classifies against squared
// thresholds and holds the output transaction. Depends on sec_pkg.
module sec_back
	import sec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  grad_item_t  q_data,
	output logic        q_pop,
	input  logic [THR_W-1:0] low_threshold,
	input  logic [THR_W-1:0] high_threshold,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_row[8:0], out_col[17:9], magnitude_sq[38:18],
	                               // edge_class[40:39], zero fill
	output logic        m_tlast    // frame_last
);

	logic [THR_SQ_W-1:0] lo_sq_q, hi_sq_q;

	logic signed [2*GRAD_W-1:0] gv_sq, gh_sq;

	logic                 v_s2;
	logic [SQ_W-1:0]      gv_sq_s2, gh_sq_s2;
	logic [OUT_POS_W-1:0] row_s2, col_s2;
	logic                 last_s2;

	logic                 out_adv, s2_load;
	logic [MAG_W-1:0]     mag;
	logic [CLASS_W-1:0]   cls;

	logic [OUT_POS_W-1:0] row_q, col_q;
	logic [MAG_W-1:0]     mag_q;
	logic [CLASS_W-1:0]   cls_q;
	logic                 last_q;
	logic                 valid_q;

	// squares of static thresholds; config is to change only while idle, which the block does not enforce
	always_ff @(posedge clk) begin
		lo_sq_q <= THR_SQ_W'(low_threshold) * THR_SQ_W'(low_threshold);
		hi_sq_q <= THR_SQ_W'(high_threshold) * THR_SQ_W'(high_threshold);
	end

	assign out_adv = !valid_q || m_tready;
	assign s2_load = !v_s2 || out_adv;
	assign q_pop   = q_valid && s2_load;

	assign gv_sq = q_data.grad_v * q_data.grad_v;
	assign gh_sq = q_data.grad_h * q_data.grad_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (s2_load) begin
				v_s2 <= q_valid;
			end
			if (out_adv) begin
				valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gv_sq_s2 <= gv_sq[SQ_W-1:0];
			gh_sq_s2 <= gh_sq[SQ_W-1:0];
			row_s2   <= q_data.out_row;
			col_s2   <= q_data.out_col;
			last_s2  <= q_data.frame_last;
		end
	end

	assign mag = MAG_W'(gv_sq_s2) + MAG_W'(gh_sq_s2);

	// low compare first: inverted thresholds give none or strong only
	always_comb begin
		if (THR_SQ_W'(mag) < lo_sq_q) begin
			cls = CLASS_NONE;
		end else if (THR_SQ_W'(mag) < hi_sq_q) begin
			cls = CLASS_WEAK;
		end else begin
			cls = CLASS_STRONG;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s2) begin
			row_q  <= row_s2;
			col_q  <= col_s2;
			mag_q  <= mag;
			cls_q  <= cls;
			last_q <= last_s2;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, cls_q, mag_q, col_q, row_q};
	assign m_tlast  = last_q;

endmodule
